// ===== hw/rtl/hhpf_pkg.sv =====
package hhpf_pkg;

    localparam int MAX_HOST_LEN_DEFAULT = 40;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 64;
    localparam int HOST_LEN_W = 6;
    localparam int FIELD_OFFSET_W = 8;
    localparam logic [FIELD_OFFSET_W-1:0] FIELD_OFFSET_RESET = 8'd22;
    localparam int POS_W = 16;
    localparam int IP_HDR_W = 6;
    localparam int PAYLOAD_W = 7;
    localparam int START_W = 9;
    localparam logic [PAYLOAD_W-1:0] TCP_OFFSET_BYTE = 7'd12;
    localparam logic [3:0] IPV4_VERSION = 4'd4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HOST_WORD_0       = 3'd0,
        REG_HOST_WORD_1       = 3'd1,
        REG_HOST_WORD_2       = 3'd2,
        REG_HOST_WORD_3       = 3'd3,
        REG_HOST_WORD_4       = 3'd4,
        REG_HOST_LENGTH       = 3'd5,
        REG_HOST_FIELD_OFFSET = 3'd6
    } hhpf_reg_t;

    typedef struct packed {
        logic [HOST_LEN_W-1:0]     host_len;
        logic [FIELD_OFFSET_W-1:0] field_offset;
    } hhpf_cfg_t;

endpackage

// ===== hw/rtl/hhpf_pattern_store.sv =====
module hhpf_pattern_store #(
    parameter int MAX_HOST_LEN = hhpf_pkg::MAX_HOST_LEN_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [hhpf_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  logic [hhpf_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic [hhpf_pkg::HOST_LEN_W-1:0]     byte_sel,
    output hhpf_pkg::hhpf_cfg_t                 cfg,
    output logic [7:0]                          pattern_byte
);
    import hhpf_pkg::*;

    localparam int IDX_W = (MAX_HOST_LEN > 1) ? $clog2(MAX_HOST_LEN) : 1;

    logic [7:0]                pattern_reg [MAX_HOST_LEN];
    logic [HOST_LEN_W-1:0]     host_length_reg;
    logic [FIELD_OFFSET_W-1:0] field_offset_reg;

    // Pattern bytes reset to zero, matching the register reset values.
    for (genvar j = 0; j < MAX_HOST_LEN; j++) begin : g_byte
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                pattern_reg[j] <= 8'd0;
            end else if (cfg_wr_en &&
                         cfg_addr == CFG_IDX_W'(int'(REG_HOST_WORD_0) + j / 8)) begin
                pattern_reg[j] <= cfg_wdata[8 * (j % 8) +: 8];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            host_length_reg  <= '0;
            field_offset_reg <= FIELD_OFFSET_RESET;
        end else if (cfg_wr_en) begin
            if (cfg_addr == REG_HOST_LENGTH) begin
                host_length_reg <= cfg_wdata[HOST_LEN_W-1:0];
            end
            if (cfg_addr == REG_HOST_FIELD_OFFSET) begin
                field_offset_reg <= cfg_wdata[FIELD_OFFSET_W-1:0];
            end
        end
    end

    always_comb begin
        cfg.host_len     = (host_length_reg > HOST_LEN_W'(MAX_HOST_LEN)) ?
                           HOST_LEN_W'(MAX_HOST_LEN) : host_length_reg;
        cfg.field_offset = field_offset_reg;
    end

    // The select reaches at most the used length; a byte is compared only while the select is below it.
    assign pattern_byte = pattern_reg[byte_sel[IDX_W-1:0]];

endmodule

// ===== hw/rtl/http_host_packet_filter_core.sv =====
// A result word is loaded into the output register when the last packet word leaves the input register.
// Throughput: one packet word per cycle; a new word is taken while a result waits.
// A last word stalls only while an untaken result still occupies the output register.
// Reset (aresetn low at a clock edge) clears the packet state, the pipeline valid
// bits and the configuration registers, with host_field_offset returning to 22.
module http_host_packet_filter_core #(
    parameter int MAX_HOST_LEN = hhpf_pkg::MAX_HOST_LEN_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [7:0]                      s_pkt_byte,
    input  logic                            s_last_byte,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_drop,
    output logic                            m_ipv4_seen,
    input  logic                            cfg_wr_en,
    input  logic [hhpf_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [hhpf_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import hhpf_pkg::*;

    hhpf_cfg_t cfg;
    logic [7:0] pattern_byte;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       advance;

    logic [POS_W-1:0]      byte_position_reg, byte_position_next;
    logic [IP_HDR_W-1:0]   ip_header_bytes_reg, ip_header_bytes_next;
    logic [PAYLOAD_W-1:0]  payload_start_reg, payload_start_next;
    logic                  version_ok_reg, version_ok_next;
    logic                  still_matching_reg, still_matching_next;
    logic [HOST_LEN_W-1:0] compare_count_reg, compare_count_next;

    logic                  m_valid_reg, m_valid_next;
    logic                  m_drop_reg, m_drop_next;
    logic                  m_ipv4_seen_reg, m_ipv4_seen_next;

    logic [PAYLOAD_W-1:0]  tcp_pos;
    logic [START_W-1:0]    window_start;
    logic                  in_window;

    hhpf_pattern_store #(
        .MAX_HOST_LEN(MAX_HOST_LEN)
    ) u_pattern_store (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .byte_sel    (compare_count_reg),
        .cfg         (cfg),
        .pattern_byte(pattern_byte)
    );

    assign advance = in_valid_reg && (!in_last_reg || !m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg <= s_pkt_byte;
            in_last_reg <= s_last_byte;
        end
    end

    always_comb begin
        tcp_pos      = PAYLOAD_W'(ip_header_bytes_reg) + TCP_OFFSET_BYTE;
        window_start = START_W'(payload_start_reg) + START_W'(cfg.field_offset);
        in_window    = (window_start > START_W'(tcp_pos))
                    && (byte_position_reg >= POS_W'(window_start))
                    && (compare_count_reg < cfg.host_len);

        byte_position_next   = byte_position_reg;
        ip_header_bytes_next = ip_header_bytes_reg;
        payload_start_next   = payload_start_reg;
        version_ok_next      = version_ok_reg;
        still_matching_next  = still_matching_reg;
        compare_count_next   = compare_count_reg;

        if (byte_position_reg == '0) begin
            version_ok_next      = (in_byte_reg[7:4] == IPV4_VERSION);
            ip_header_bytes_next = {in_byte_reg[3:0], 2'b00};
        end else if (byte_position_reg == POS_W'(tcp_pos)) begin
            payload_start_next = PAYLOAD_W'(ip_header_bytes_reg)
                               + PAYLOAD_W'({in_byte_reg[7:4], 2'b00});
        end else if (byte_position_reg > POS_W'(tcp_pos) && in_window) begin
            if (in_byte_reg != pattern_byte) begin
                still_matching_next = 1'b0;
            end
            compare_count_next = compare_count_reg + 1'b1;
        end

        if (byte_position_reg != '1) begin
            byte_position_next = byte_position_reg + 1'b1;
        end

        m_drop_next      = version_ok_next && still_matching_next
                        && (compare_count_next == cfg.host_len);
        m_ipv4_seen_next = version_ok_next;

        // The packet state returns to its reset values after the last word.
        if (in_last_reg) begin
            byte_position_next   = '0;
            ip_header_bytes_next = '0;
            payload_start_next   = '0;
            version_ok_next      = 1'b0;
            still_matching_next  = 1'b1;
            compare_count_next   = '0;
        end

        if (advance && in_last_reg) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_position_reg   <= '0;
            ip_header_bytes_reg <= '0;
            payload_start_reg   <= '0;
            version_ok_reg      <= 1'b0;
            still_matching_reg  <= 1'b1;
            compare_count_reg   <= '0;
            m_valid_reg         <= 1'b0;
        end else begin
            if (advance) begin
                byte_position_reg   <= byte_position_next;
                ip_header_bytes_reg <= ip_header_bytes_next;
                payload_start_reg   <= payload_start_next;
                version_ok_reg      <= version_ok_next;
                still_matching_reg  <= still_matching_next;
                compare_count_reg   <= compare_count_next;
            end
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_last_reg) begin
            m_drop_reg      <= m_drop_next;
            m_ipv4_seen_reg <= m_ipv4_seen_next;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_drop      = m_drop_reg;
    assign m_ipv4_seen = m_ipv4_seen_reg;

endmodule

// ===== bench/http_host_packet_filter_core_tb.sv =====
`timescale 1ns / 100ps

module http_host_packet_filter_core_tb;
    import hhpf_pkg::*;

    typedef struct packed {
        logic drop;
        logic ipv4_seen;
    } verdict_t;

    typedef enum int {
        PATTERN_RANDOM,
        PATTERN_ZEROS,
        PATTERN_ONES
    } pattern_fill_t;

    class host_filter_scoreboard;
        logic [CFG_DATA_W-1:0]     host_word [5];
        logic [HOST_LEN_W-1:0]     host_len;
        logic [FIELD_OFFSET_W-1:0] field_off;
        logic [POS_W-1:0]          byte_pos;
        logic [IP_HDR_W-1:0]       ip_hdr_len;
        logic [PAYLOAD_W-1:0]      payload_start;
        logic [HOST_LEN_W-1:0]     compare_cnt;
        bit                        version_ok;
        bit                        still_matching;
        verdict_t                  verdict_q [$];
        int                        failures;
        int                        reported;
        int                        packets_noted;

        function new();
            foreach (host_word[i]) begin
                host_word[i] = '0;
            end
            host_len = '0;
            field_off = FIELD_OFFSET_RESET;
            failures = 0;
            reported = 0;
            packets_noted = 0;
            clear_packet();
        endfunction

        function void clear_packet();
            byte_pos = '0;
            ip_hdr_len = '0;
            payload_start = '0;
            compare_cnt = '0;
            version_ok = 1'b0;
            still_matching = 1'b1;
        endfunction

        function void set_reg(hhpf_reg_t idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                REG_HOST_LENGTH: begin
                    host_len = value[HOST_LEN_W-1:0];
                end
                REG_HOST_FIELD_OFFSET: begin
                    field_off = value[FIELD_OFFSET_W-1:0];
                end
                default: begin
                    host_word[int'(idx)] = value;
                end
            endcase
        endfunction

        function int used_len();
            return (host_len > MAX_HOST_LEN_DEFAULT) ? MAX_HOST_LEN_DEFAULT : int'(host_len);
        endfunction

        function logic [7:0] pattern_byte(int k);
            return host_word[k / 8][(k % 8) * 8 +: 8];
        endfunction

        function int pending();
            return verdict_q.size();
        endfunction

        function void note_word(logic [7:0] b, logic last);
            int       tcp_pos;
            int       start;
            verdict_t v;
            tcp_pos = int'(ip_hdr_len) + int'(TCP_OFFSET_BYTE);
            if (byte_pos == 0) begin
                version_ok = (b[7:4] == IPV4_VERSION);
                ip_hdr_len = {b[3:0], 2'b00};
            end else if (byte_pos == tcp_pos) begin
                payload_start = PAYLOAD_W'(int'(ip_hdr_len) + 4 * int'(b[7:4]));
            end else if (byte_pos > tcp_pos) begin
                start = int'(payload_start) + int'(field_off);
                if (start > tcp_pos && byte_pos >= start && compare_cnt < used_len()) begin
                    if (b != pattern_byte(int'(compare_cnt))) begin
                        still_matching = 1'b0;
                    end
                    compare_cnt++;
                end
            end
            if (byte_pos != '1) begin
                byte_pos++;
            end
            if (last) begin
                v.drop = version_ok && still_matching && (compare_cnt == used_len());
                v.ipv4_seen = version_ok;
                verdict_q.push_back(v);
                packets_noted++;
                clear_packet();
            end
        endfunction

        function void check_verdict(logic drop, logic ipv4_seen);
            verdict_t want;
            if (verdict_q.size() == 0) begin
                failures++;
                if (reported < 10) begin
                    reported++;
                    $display("%0t: verdict with none expected, drop=%0b ipv4_seen=%0b",
                             $time, drop, ipv4_seen);
                end
                return;
            end
            want = verdict_q.pop_front();
            if (want.drop !== drop || want.ipv4_seen !== ipv4_seen) begin
                failures++;
                if (reported < 10) begin
                    reported++;
                    $display("%0t: mismatch, expected drop=%0b ipv4=%0b, got drop=%0b ipv4=%0b",
                             $time, want.drop, want.ipv4_seen, drop, ipv4_seen);
                end
            end
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [7:0]            s_pkt_byte = '0;
    logic                  s_last_byte = 1'b0;
    logic                  m_valid;
    logic                  m_ready = 1'b1;
    logic                  m_drop;
    logic                  m_ipv4_seen;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    host_filter_scoreboard sb = new();

    bit         idle_on = 1'b1;
    bit         rx_stall_on = 1'b1;
    int         rx_count = 0;
    int         burst_left = 0;
    int         bytes_sent = 0;
    logic [7:0] pkt_q [$];

    http_host_packet_filter_core dut (.*);

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        if (rx_count == 0) begin
            if (m_ready && rx_stall_on) begin
                m_ready <= 1'b0;
                rx_count <= $urandom_range(0, 6);
            end else begin
                m_ready <= 1'b1;
                rx_count <= $urandom_range(1, 12);
            end
        end else begin
            rx_count <= rx_count - 1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                sb.note_word(s_pkt_byte, s_last_byte);
            end
            if (m_valid && m_ready) begin
                sb.check_verdict(m_drop, m_ipv4_seen);
            end
        end
    end

    task automatic send_word(input logic [7:0] b, input logic last);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = idle_on ? $urandom_range(0, 6) : 0;
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_pkt_byte <= b;
        s_last_byte <= last;
        do @(posedge aclk); while (!s_ready);
        bytes_sent++;
    endtask

    task automatic send_packet();
        int i;
        for (i = 0; i < pkt_q.size(); i++) begin
            send_word(pkt_q[i], i == pkt_q.size() - 1);
        end
    endtask

    task automatic wait_empty();
        s_valid <= 1'b0;
        do @(negedge aclk); while (sb.pending() != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input hhpf_reg_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= value;
        sb.set_reg(idx, value);
        @(posedge aclk);
    endtask

    task automatic program_filter(input pattern_fill_t fill, input int len, input int offset);
        int                    i;
        logic [CFG_DATA_W-1:0] w;
        wait_empty();
        for (i = 0; i < 5; i++) begin
            case (fill)
                PATTERN_ZEROS: begin
                    w = '0;
                end
                PATTERN_ONES: begin
                    w = '1;
                end
                default: begin
                    w = {$urandom, $urandom};
                end
            endcase
            write_reg(hhpf_reg_t'(int'(REG_HOST_WORD_0) + i), w);
        end
        w = {$urandom, $urandom};
        w[HOST_LEN_W-1:0] = HOST_LEN_W'(len);
        write_reg(REG_HOST_LENGTH, w);
        w = {$urandom, $urandom};
        w[FIELD_OFFSET_W-1:0] = FIELD_OFFSET_W'(offset);
        write_reg(REG_HOST_FIELD_OFFSET, w);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic build_packet(input logic [3:0] ver, input int ihl, input int doff,
                                input int corrupt_at, input int cut_len, input int tail);
        int         tcp_pos;
        int         start;
        int         k;
        logic [7:0] b;
        tcp_pos = 4 * ihl + 12;
        start = ((4 * ihl + 4 * doff) & 127) + int'(sb.field_off);
        pkt_q.delete();
        pkt_q.push_back({ver, 4'(ihl)});
        while (pkt_q.size() < tcp_pos) begin
            pkt_q.push_back(8'($urandom));
        end
        pkt_q.push_back({4'(doff), 4'($urandom)});
        while (pkt_q.size() < start) begin
            pkt_q.push_back(8'($urandom));
        end
        for (k = 0; k < sb.used_len(); k++) begin
            b = sb.pattern_byte(k);
            if (k == corrupt_at) begin
                b = b ^ 8'($urandom_range(1, 255));
            end
            pkt_q.push_back(b);
        end
        repeat (tail) pkt_q.push_back(8'($urandom));
        if (cut_len > 0 && cut_len < pkt_q.size()) begin
            pkt_q = pkt_q[0:cut_len-1];
        end
    endtask

    task automatic build_random_packet();
        int         kind;
        int         ihl;
        int         doff;
        int         len;
        int         corrupt;
        int         tail;
        logic [3:0] ver;
        kind = $urandom_range(0, 19);
        ihl = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 5);
        doff = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(3, 5);
        len = sb.used_len();
        corrupt = -1;
        if (len > 0 && $urandom_range(0, 2) == 0) begin
            corrupt = $urandom_range(0, len - 1);
        end
        tail = $urandom_range(0, 4);
        ver = IPV4_VERSION;
        if (kind < 3) begin
            pkt_q.delete();
            repeat ($urandom_range(1, 30)) pkt_q.push_back(8'($urandom));
        end else begin
            if (kind < 5) begin
                ver = 4'($urandom_range(0, 15));
                if (ver == IPV4_VERSION) begin
                    ver = ver + 4'd1;
                end
            end
            build_packet(ver, ihl, doff, corrupt, 0, tail);
            if (kind < 8 && pkt_q.size() > 1) begin
                pkt_q = pkt_q[0:$urandom_range(0, pkt_q.size() - 2)];
            end
        end
    endtask

    initial begin
        int            n;
        int            r;
        int            len;
        int            offset;
        int            target;
        int            base;
        pattern_fill_t fill;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        build_packet(IPV4_VERSION, 5, 5, -1, 1, 0);
        send_packet();
        build_packet(4'h6, 15, 5, -1, 1, 0);
        send_packet();
        build_packet(IPV4_VERSION, 5, 5, -1, 0, 3);
        send_packet();

        program_filter(PATTERN_RANDOM, 8, 1);
        build_packet(IPV4_VERSION, 0, 3, -1, 0, 2);
        send_packet();
        build_packet(IPV4_VERSION, 0, 3, 0, 0, 0);
        send_packet();
        build_packet(IPV4_VERSION, 1, 4, 7, 0, 1);
        send_packet();
        build_packet(IPV4_VERSION, 0, 3, -1, 17, 0);
        send_packet();
        build_packet(IPV4_VERSION, 0, 0, -1, 0, 10);
        send_packet();
        build_packet(4'h6, 0, 3, -1, 0, 0);
        send_packet();
        build_packet(IPV4_VERSION, 2, 5, -1, 5, 0);
        send_packet();

        program_filter(PATTERN_ZEROS, 40, 255);
        build_packet(IPV4_VERSION, 15, 15, -1, 0, 1);
        send_packet();
        build_packet(IPV4_VERSION, 15, 15, 39, 0, 0);
        send_packet();

        program_filter(PATTERN_ONES, 63, 0);
        build_packet(IPV4_VERSION, 0, 4, -1, 0, 0);
        send_packet();
        build_packet(IPV4_VERSION, 0, 3, -1, 0, 45);
        send_packet();

        target = bytes_sent + 1150;
        base = sb.packets_noted;
        while (bytes_sent < target || sb.packets_noted - base < 48) begin
            r = $urandom_range(0, 9);
            case (r)
                0: fill = PATTERN_ZEROS;
                1: fill = PATTERN_ONES;
                default: fill = PATTERN_RANDOM;
            endcase
            r = $urandom_range(0, 9);
            if (r < 6) begin
                len = $urandom_range(0, 8);
            end else if (r < 8) begin
                len = $urandom_range(9, 40);
            end else if (r == 8) begin
                len = $urandom_range(41, 63);
            end else begin
                len = 0;
            end
            r = $urandom_range(0, 9);
            if (r < 6) begin
                offset = $urandom_range(0, 8);
            end else if (r < 8) begin
                offset = $urandom_range(9, 40);
            end else begin
                offset = $urandom_range(0, 255);
            end
            program_filter(fill, len, offset);
            idle_on = ($urandom_range(0, 3) != 0);
            rx_stall_on <= ($urandom_range(0, 3) != 0);
            n = $urandom_range(3, 8);
            repeat (n) begin
                if ($urandom_range(0, 9) == 0) begin
                    wait_empty();
                end
                build_random_packet();
                send_packet();
            end
        end

        wait_empty();
        repeat (10) @(posedge aclk);
        if (sb.failures == 0 && sb.pending() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #12000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/hhpf_pkg.sv
hw/rtl/hhpf_pattern_store.sv
hw/rtl/http_host_packet_filter_core.sv
bench/http_host_packet_filter_core_tb.sv
